/* hdl/taa_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle area accumulator package
// Widths, item types and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package taa_pkg;

  localparam int unsigned CoordWidth  = 24;
  localparam int unsigned TotalWidth  = 60;
  localparam int unsigned DiffWidth   = CoordWidth + 1;
  localparam int unsigned ProdWidth   = 2 * DiffWidth;
  localparam int unsigned CompWidth   = ProdWidth + 1;
  localparam int unsigned MagWidth    = CompWidth - 1;
  localparam int unsigned HalfWidth   = MagWidth / 2;
  localparam int unsigned SqWidth     = 2 * MagWidth;
  localparam int unsigned AccWidth    = SqWidth + 2;
  localparam int unsigned RootWidth   = AccWidth / 2;
  localparam int unsigned AreaWidth   = 2 * CoordWidth;
  localparam int unsigned SumWidth    = CoordWidth + 2;
  localparam int unsigned MeanWidth   = SumWidth + 2;
  localparam int unsigned InWidth     = 9 * CoordWidth;
  localparam int unsigned OutWidth    = AreaWidth + 3 * CoordWidth + TotalWidth + 1;
  localparam int unsigned InBytes     = (InWidth + 7) / 8;
  localparam int unsigned OutBytes    = (OutWidth + 7) / 8;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned FrontStages = 6;
  localparam int unsigned SqrtSteps   = RootWidth;
  localparam int unsigned StepWidth   = $clog2(SqrtSteps + 1);

  localparam logic [MeanWidth-1:0] MeanOffset = MeanWidth'(1 << (SumWidth - 1));
  localparam logic [MeanWidth-1:0] MeanBias   = MeanWidth'(3 * (1 << (SumWidth - 1)) + 1);
  localparam logic [MeanWidth-1:0] MeanRecip  = MeanWidth'((1 << MeanWidth) / 3 + 1);

  typedef struct packed {
    logic [AccWidth-1:0]   norm_sq;
    logic [CoordWidth-1:0] cen_x;
    logic [CoordWidth-1:0] cen_y;
    logic [CoordWidth-1:0] cen_z;
    logic                  first;
  } tri_entry_t;

  // round-to-nearest mean of three coordinates
  function automatic logic [CoordWidth-1:0] mean3(input logic signed [SumWidth-1:0] s);
    logic [MeanWidth-1:0]   u;
    logic [2*MeanWidth-1:0] p;
    logic [MeanWidth-1:0]   q;
    u = {{2{s[SumWidth-1]}}, s} + MeanBias;
    p = u * MeanRecip;
    q = p[2*MeanWidth-1 -: MeanWidth] - MeanOffset;
    return q[CoordWidth-1:0];
  endfunction

endpackage

/* hdl/taa_front.sv */
// ----------------------------------------------------------------------------
// Triangle area front end
// Pipelined edge, cross product and squared norm; centroid per triangle.
// ----------------------------------------------------------------------------
module taa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [taa_pkg::InWidth-1:0]   in_data_i,
  input  logic                          in_first_i,
  output logic                          ent_valid_o,
  input  logic                          ent_ready_i,
  output taa_pkg::tri_entry_t           ent_o
);
  import taa_pkg::*;

  typedef logic signed [CoordWidth-1:0] crd_t;
  typedef logic signed [DiffWidth-1:0]  dif_t;
  typedef logic signed [ProdWidth-1:0]  prd_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  typedef struct packed {
    logic [CoordWidth-1:0] cen_x;
    logic [CoordWidth-1:0] cen_y;
    logic [CoordWidth-1:0] cen_z;
    logic                  first;
  } side_t;

  crd_t c [9];
  logic [FrontStages-1:0] v_q;
  logic adv;
  dif_t ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  sum_t sx_q, sy_q, sz_q;
  logic f_q;
  prd_t p_q [6];
  logic [MagWidth-1:0] m_q [3];
  logic [MagWidth-1:0] hh_q [3];
  logic [MagWidth-1:0] hl_q [3];
  logic [MagWidth-1:0] ll_q [3];
  logic [SqWidth-1:0]  s_q [3];
  logic [AccWidth-1:0] norm_q;
  side_t side_q [FrontStages-1];
  logic signed [CompWidth-1:0] d [3];

  always_comb begin
    for (int i = 0; i < 9; i++) c[i] = crd_t'(in_data_i[i*CoordWidth +: CoordWidth]);
  end

  assign adv = !v_q[FrontStages-1] || ent_ready_i;
  assign in_ready_o = adv;
  assign ent_valid_o = v_q[FrontStages-1];
  assign ent_o = tri_entry_t'({norm_q, side_q[FrontStages-2]});

  always_comb begin
    d[0] = CompWidth'(p_q[0]) - CompWidth'(p_q[1]);
    d[1] = CompWidth'(p_q[2]) - CompWidth'(p_q[3]);
    d[2] = CompWidth'(p_q[4]) - CompWidth'(p_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[FrontStages-2:0], in_valid_i};
    end
  end

  // squares split into halves: m^2 = hh*2^(2H) + 2*hl*2^H + ll
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux_q <= dif_t'(c[3]) - dif_t'(c[0]);
      uy_q <= dif_t'(c[4]) - dif_t'(c[1]);
      uz_q <= dif_t'(c[5]) - dif_t'(c[2]);
      vx_q <= dif_t'(c[6]) - dif_t'(c[0]);
      vy_q <= dif_t'(c[7]) - dif_t'(c[1]);
      vz_q <= dif_t'(c[8]) - dif_t'(c[2]);
      sx_q <= sum_t'(c[0]) + sum_t'(c[3]) + sum_t'(c[6]);
      sy_q <= sum_t'(c[1]) + sum_t'(c[4]) + sum_t'(c[7]);
      sz_q <= sum_t'(c[2]) + sum_t'(c[5]) + sum_t'(c[8]);
      f_q <= in_first_i;
      p_q[0] <= uy_q * vz_q; p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q; p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q; p_q[5] <= uy_q * vx_q;
      side_q[0] <= '{cen_x: mean3(sx_q), cen_y: mean3(sy_q), cen_z: mean3(sz_q), first: f_q};
      for (int i = 1; i < FrontStages - 1; i++) side_q[i] <= side_q[i-1];
      for (int i = 0; i < 3; i++) begin
        m_q[i] <= MagWidth'(d[i][CompWidth-1] ? -d[i] : d[i]);
        hh_q[i] <= m_q[i][MagWidth-1 -: HalfWidth] * m_q[i][MagWidth-1 -: HalfWidth];
        hl_q[i] <= m_q[i][MagWidth-1 -: HalfWidth] * m_q[i][HalfWidth-1:0];
        ll_q[i] <= m_q[i][HalfWidth-1:0] * m_q[i][HalfWidth-1:0];
        s_q[i] <= {hh_q[i], ll_q[i]} + (SqWidth'(hl_q[i]) << (HalfWidth + 1));
      end
      norm_q <= AccWidth'(s_q[0]) + AccWidth'(s_q[1]) + AccWidth'(s_q[2]);
    end
  end

endmodule

/* hdl/taa_back.sv */
// ----------------------------------------------------------------------------
// Triangle area back end
// Digit-by-digit square root, halving and saturating running total.
// ----------------------------------------------------------------------------
module taa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ent_valid_i,
  output logic                          ent_ready_o,
  input  taa_pkg::tri_entry_t           ent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [taa_pkg::OutWidth-1:0]  out_data_o
);
  import taa_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StSum  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] st_q;
  logic [AccWidth-1:0]  x_q;
  logic [RootWidth+1:0] rem_q;
  logic [RootWidth-1:0] root_q;
  logic [StepWidth-1:0] k_q;
  tri_entry_t e_q;
  logic [TotalWidth-1:0] sum_q;
  logic sat_q;
  logic [AreaWidth-1:0] area_q;
  logic [RootWidth+1:0] rem_sh, trial;
  logic [TotalWidth:0] tot;
  logic [TotalWidth-1:0] base;

  assign ent_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign rem_sh = {rem_q[RootWidth-1:0], x_q[AccWidth-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign base = e_q.first ? '0 : sum_q;
  assign tot = {1'b0, base} + (TotalWidth+1)'(area_q);
  assign out_data_o = {sat_q, sum_q, e_q.cen_z, e_q.cen_y, e_q.cen_x, area_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; sum_q <= '0; sat_q <= 1'b0;
    end else begin
      case (st_q)
        StIdle: if (ent_valid_i) begin
          st_q <= StRoot;
        end
        StRoot: if (k_q == StepWidth'(SqrtSteps - 1)) st_q <= StSum;
        StSum: begin
          st_q <= StOut;
          if (tot[TotalWidth]) begin
            sum_q <= '1; sat_q <= 1'b1;
          end else begin
            sum_q <= tot[TotalWidth-1:0]; sat_q <= e_q.first ? 1'b0 : sat_q;
          end
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        e_q <= ent_i; x_q <= ent_i.norm_sq; rem_q <= '0; root_q <= '0; k_q <= '0;
      end
      StRoot: begin
        x_q <= {x_q[AccWidth-3:0], 2'b00};
        k_q <= k_q + StepWidth'(1);
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial; root_q <= {root_q[RootWidth-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh; root_q <= {root_q[RootWidth-2:0], 1'b0};
        end
      end
      StSum: ;
      StOut: ;
      default: ;
    endcase
    if (st_q == StRoot && k_q == StepWidth'(SqrtSteps - 1)) begin
      if (rem_sh >= trial) begin
        if ({root_q[RootWidth-2:0], 1'b1} >> 1 > RootWidth'({AreaWidth{1'b1}}))
          area_q <= '1;
        else area_q <= AreaWidth'({root_q[RootWidth-2:0], 1'b1} >> 1);
      end else begin
        if ({root_q[RootWidth-2:0], 1'b0} >> 1 > RootWidth'({AreaWidth{1'b1}}))
          area_q <= '1;
        else area_q <= AreaWidth'({root_q[RootWidth-2:0], 1'b0} >> 1);
      end
    end
  end

endmodule

/* hdl/triangle_area_accumulator.sv */
// ----------------------------------------------------------------------------
// Triangle area accumulator
// Per-triangle area, centroid and saturating running mesh area.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata: a_x..c_z; tuser: first_of_mesh
// m_axis    out  tdata: area, centroid_x/y/z, total_area, total_overflow
// A triangle passes through the front pipeline and the queue, then the back
// end: a load, 51 square-root steps, the sum and the output state. The
// bit-serial square root takes no new triangle until its result is taken.
// Reset clears the running total and the overflow flag.
// Either side stalls independently; the front pipeline holds while its last stage waits.
module triangle_area_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [taa_pkg::InBytes*8-1:0]   s_axis_tdata_i,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
  input  logic                            s_axis_tuser_i,  // first_of_mesh
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [taa_pkg::OutBytes*8-1:0]  m_axis_tdata_o   // area,cen_x,cen_y,cen_z,total,ovf
);
  import taa_pkg::*;

  logic       fv, fr, qv, qr;
  tri_entry_t fe, qe;
  tri_entry_t q_mem [QueueDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [OutWidth-1:0] od;

  taa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_data_i(s_axis_tdata_i[InWidth-1:0]), .in_first_i(s_axis_tuser_i),
    .ent_valid_o(fv), .ent_ready_i(fr), .ent_o(fe)
  );

  assign fr = (cnt_q != 2'(QueueDepth));
  assign qv = (cnt_q != '0);
  assign qe = q_mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (fv && fr) wp_q <= wp_q + 1'b1;
      if (qv && qr) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(fv && fr) - 2'(qv && qr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fv && fr) q_mem[wp_q] <= fe;
  end

  taa_back u_back (
    .clk_i, .rst_ni,
    .ent_valid_i(qv), .ent_ready_o(qr), .ent_i(qe),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_data_o(od)
  );

  assign m_axis_tdata_o = (OutBytes*8)'(od);

endmodule
